FILE: rtl/core/sha256_pkg.sv
// sha256_pkg: shared types, constants and round functions for the sha-256 hasher
// no dependencies
package sha256_pkg;

    localparam int unsigned WordWidth   = 32;
    localparam int unsigned BlockBytes  = 64;
    localparam int unsigned LenBytePos  = 56;
    localparam logic [7:0]  PadByte     = 8'h80;
    localparam logic [63:0] BlockBits   = 64'd512;

    typedef enum logic {
        OP_ABSORB = 1'b0,
        OP_FINISH = 1'b1
    } op_t;

    typedef struct packed {
        logic       opcode;
        logic [7:0] data_byte;
    } in_beat_t;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        last_word;
    } out_beat_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_ROUND,
        ST_UPDATE,
        ST_PAD,
        ST_EMIT
    } state_t;

    // commands from controller to datapath
    typedef struct packed {
        logic       write_byte;
        logic [5:0] byte_addr;
        logic [7:0] byte_value;
        logic       load_init;
        logic       round_en;
        logic [5:0] round_idx;
        logic       update_hash;
        logic       reset_hash;
        logic [2:0] emit_idx;
    } dp_cmd_t;

    localparam logic [31:0] InitHash [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] RoundK [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
        rotr = (x >> n) | (x << (32 - n));
    endfunction

    function automatic logic [31:0] big_sigma0(input logic [31:0] x);
        big_sigma0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
    endfunction

    function automatic logic [31:0] big_sigma1(input logic [31:0] x);
        big_sigma1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
    endfunction

    function automatic logic [31:0] small_sigma0(input logic [31:0] x);
        small_sigma0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
    endfunction

    function automatic logic [31:0] small_sigma1(input logic [31:0] x);
        small_sigma1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
    endfunction

endpackage

FILE: rtl/core/sha256_ram.sv
// sha256_ram: generic simple dual-port ram (one write port, one read port) with registered read
// no dependencies
module sha256_ram #(
    parameter int unsigned Width = 8,
    parameter int unsigned Depth = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(Depth)-1:0] waddr,
    input  logic [Width-1:0]         wdata,
    input  logic [$clog2(Depth)-1:0] raddr,
    output logic [Width-1:0]         rdata
);

    logic [Width-1:0] mem [Depth];

    // write port and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: rtl/core/sha256_datapath.sv
// sha256_datapath: block buffer, schedule window, round registers and hash words
// depends on sha256_pkg and sha256_ram
module sha256_datapath
    import sha256_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  dp_cmd_t     cmd,
    input  logic [5:0]  load_addr,
    input  logic        load_en,
    output logic [31:0] emit_word
);

    logic [7:0]  rd_byte;
    logic [31:0] w_reg [16];
    logic [31:0] w_next_word;
    logic [31:0] v_reg [8];
    logic [31:0] h_reg [8];
    logic [31:0] shift_word;
    logic [31:0] t1;
    logic [31:0] t2;
    logic [31:0] w_cur;
    logic        w_fresh;

    // block byte buffer
    sha256_ram #(
        .Width (8),
        .Depth (BlockBytes)
    ) u_block_ram (
        .clk   (clk),
        .we    (cmd.write_byte),
        .waddr (cmd.byte_addr),
        .wdata (cmd.byte_value),
        .raddr (load_addr),
        .rdata (rd_byte)
    );

    // byte packing into the window: new byte enters at the bottom of w[15]
    assign shift_word = {w_reg[15][23:0], rd_byte};

    // schedule expansion, from round 16 on the window holds the last sixteen words at w[0..15]
    assign w_next_word = small_sigma1(w_reg[14]) + w_reg[9] + small_sigma0(w_reg[1]) + w_reg[0];
    assign w_fresh     = (cmd.round_idx >= 6'd16);
    assign w_cur       = w_fresh ? w_next_word : w_reg[0];

    // round function
    assign t1 = v_reg[7] + big_sigma1(v_reg[4])
              + ((v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6]))
              + RoundK[cmd.round_idx] + w_cur;
    assign t2 = big_sigma0(v_reg[0])
              + ((v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]));

    // schedule window, a word moves down each round, and while loading as the first byte of the next one arrives
    always_ff @(posedge clk)
    begin
        if (load_en)
        begin
            w_reg[15] <= shift_word;
            for (int i = 0; i < 15; i++)
            begin
                if (load_addr[1:0] == 2'd1)
                begin
                    w_reg[i] <= w_reg[i + 1];
                end
            end
        end
        else if (cmd.round_en)
        begin
            for (int i = 0; i < 15; i++)
            begin
                w_reg[i] <= w_reg[i + 1];
            end
            w_reg[15] <= w_cur;
        end
    end

    // working variables
    always_ff @(posedge clk)
    begin
        if (cmd.load_init)
        begin
            for (int i = 0; i < 8; i++)
            begin
                v_reg[i] <= h_reg[i];
            end
        end
        else if (cmd.round_en)
        begin
            v_reg[0] <= t1 + t2;
            v_reg[1] <= v_reg[0];
            v_reg[2] <= v_reg[1];
            v_reg[3] <= v_reg[2];
            v_reg[4] <= v_reg[3] + t1;
            v_reg[5] <= v_reg[4];
            v_reg[6] <= v_reg[5];
            v_reg[7] <= v_reg[6];
        end
    end

    // hash words
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 8; i++)
            begin
                h_reg[i] <= InitHash[i];
            end
        end
        else if (cmd.reset_hash)
        begin
            for (int i = 0; i < 8; i++)
            begin
                h_reg[i] <= InitHash[i];
            end
        end
        else if (cmd.update_hash)
        begin
            for (int i = 0; i < 8; i++)
            begin
                h_reg[i] <= h_reg[i] + v_reg[i];
            end
        end
    end

    assign emit_word = h_reg[cmd.emit_idx];

endmodule

FILE: rtl/core/sha256_ctrl.sv
// sha256_ctrl: sequencer for absorb, padding, compression and digest output
// depends on sha256_pkg
module sha256_ctrl
    import sha256_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_fire,
    input  in_beat_t    in_beat,
    output logic        in_ready,
    input  logic        out_taken,
    output logic        out_busy,
    output logic [2:0]  out_idx,
    output logic        out_load,
    output dp_cmd_t     cmd,
    output logic [5:0]  load_addr,
    output logic        load_en
);

    state_t      state_reg, state_next;
    logic [5:0]  pend_reg, pend_next;
    logic [63:0] bits_reg, bits_next;
    logic [63:0] total_reg, total_next;
    logic [6:0]  cnt_reg, cnt_next;
    logic        fin_reg, fin_next;
    logic        second_reg, second_next;
    logic        tail_reg, tail_next;
    logic [5:0]  pad_reg, pad_next;
    logic [3:0]  emit_reg, emit_next;
    logic        byte_ok;

    // next state
    always_comb
    begin
        state_next  = state_reg;
        pend_next   = pend_reg;
        bits_next   = bits_reg;
        total_next  = total_reg;
        cnt_next    = cnt_reg;
        fin_next    = fin_reg;
        second_next = second_reg;
        tail_next   = tail_reg;
        pad_next    = pad_reg;
        emit_next   = emit_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    if (in_beat.opcode == OP_ABSORB)
                    begin
                        pend_next = pend_reg + 6'd1;
                        if (pend_reg == 6'd63)
                        begin
                            bits_next = bits_reg + BlockBits;
                            fin_next  = 1'b0;
                            cnt_next  = '0;
                            state_next = ST_LOAD;
                        end
                    end
                    else
                    begin
                        total_next  = bits_reg + {55'd0, pend_reg, 3'd0};
                        fin_next    = 1'b1;
                        second_next = (pend_reg >= 6'(LenBytePos));
                        tail_next   = 1'b0;
                        pad_next    = pend_reg;
                        state_next  = ST_PAD;
                    end
                end
            end
            ST_PAD:
            begin
                // one byte position per cycle until the block is full; the first pass writes from the pending count on
                pad_next = pad_reg + 6'd1;
                if (pad_reg == 6'd63)
                begin
                    cnt_next   = '0;
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD:
            begin
                // reads every block address, then takes in the byte of the last registered read
                cnt_next = cnt_reg + 7'd1;
                if (cnt_reg == 7'd64)
                begin
                    cnt_next   = '0;
                    state_next = ST_ROUND;
                end
            end
            ST_ROUND:
            begin
                cnt_next = cnt_reg + 7'd1;
                if (cnt_reg == 7'd63)
                begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE:
            begin
                if (!fin_reg)
                begin
                    pend_next  = '0;
                    state_next = ST_IDLE;
                end
                else if (second_reg)
                begin
                    second_next = 1'b0;
                    tail_next   = 1'b1;
                    pad_next    = '0;
                    state_next  = ST_PAD;
                end
                else
                begin
                    tail_next  = 1'b0;
                    emit_next  = '0;
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (out_taken)
                begin
                    emit_next = emit_reg + 4'd1;
                    if (emit_reg == 4'd7)
                    begin
                        pend_next  = '0;
                        bits_next  = '0;
                        fin_next   = 1'b0;
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            pend_reg   <= '0;
            bits_reg   <= '0;
            total_reg  <= '0;
            cnt_reg    <= '0;
            fin_reg    <= 1'b0;
            second_reg <= 1'b0;
            tail_reg   <= 1'b0;
            pad_reg    <= '0;
            emit_reg   <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            pend_reg   <= pend_next;
            bits_reg   <= bits_next;
            total_reg  <= total_next;
            cnt_reg    <= cnt_next;
            fin_reg    <= fin_next;
            second_reg <= second_next;
            tail_reg   <= tail_next;
            pad_reg    <= pad_next;
            emit_reg   <= emit_next;
        end
    end

    // padding byte for the current pad position
    function automatic logic [7:0] pad_byte(input logic [5:0] pos, input logic [5:0] start,
                                            input logic first, input logic extra,
                                            input logic [63:0] len);
        logic [7:0] b;
        b = 8'h00;
        if (first && pos == start)
        begin
            b = PadByte;
        end
        else if (pos >= 6'(LenBytePos) && !extra)
        begin
            b = len[8 * (7 - int'(pos[2:0])) +: 8];
        end
        pad_byte = b;
    endfunction

    // outputs
    always_comb
    begin
        byte_ok          = 1'b0;
        cmd              = '0;
        in_ready         = 1'b0;
        out_busy         = 1'b0;
        out_load         = 1'b0;
        load_en          = 1'b0;
        load_addr        = cnt_reg[5:0];
        cmd.emit_idx     = emit_reg[2:0];
        out_idx          = emit_reg[2:0];
        case (state_reg)
            ST_IDLE:
            begin
                in_ready       = 1'b1;
                byte_ok        = in_fire && (in_beat.opcode == OP_ABSORB);
                cmd.write_byte = byte_ok;
                cmd.byte_addr  = pend_reg;
                cmd.byte_value = in_beat.data_byte;
            end
            ST_PAD:
            begin
                // first pass starts at the pending count, the extra block is written whole
                cmd.write_byte = tail_reg || (pad_reg >= pend_reg);
                cmd.byte_addr  = pad_reg;
                cmd.byte_value = pad_byte(pad_reg, pend_reg, !tail_reg, second_reg, total_reg);
            end
            ST_LOAD:
            begin
                load_en        = (cnt_reg != 7'd0);
                load_addr      = cnt_reg[5:0];
                cmd.load_init  = (cnt_reg == 7'd64);
            end
            ST_ROUND:
            begin
                cmd.round_en  = 1'b1;
                cmd.round_idx = cnt_reg[5:0];
            end
            ST_UPDATE:
            begin
                cmd.update_hash = 1'b1;
            end
            ST_EMIT:
            begin
                out_busy = 1'b1;
                out_load = 1'b1;
                cmd.reset_hash = out_taken && (emit_reg == 4'd7);
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

`ifndef SYNTHESIS
    // pending count moves only in idle, after a full block is compressed or when a message ends; checked in rounds
    a_pend_stable: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ROUND) |=> $stable(pend_reg))
        else $error("pending count moved during compression");
    // the round state hands over to the update state after round 63
    a_round_exit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ROUND && cnt_reg == 7'd63) |=> (state_reg == ST_UPDATE))
        else $error("round count mismatch");
    // no input accepted outside idle
    a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> (state_reg == ST_IDLE))
        else $error("ready outside idle");
`endif

endmodule

FILE: rtl/core/sha256_message_hasher.sv
// sha256_message_hasher: streaming sha-256 top level
// depends on sha256_pkg, sha256_ctrl, sha256_datapath, sha256_ram
//
//  channel  | handshake       | payload
//  in       | in_valid/ready  | in_data  (opcode, data_byte)
//  out      | out_valid/ready | out_data (digest_word, word_index, last_word)
//
// absorb beats are taken while idle; every 64th byte starts a block load, the
// rounds and a hash update, and input waits until they are done.
// a finish beat writes padding one byte per cycle (up to 64), compresses once
// or twice, then offers eight digest beats. the single round unit sets the rate.
// reset is asynchronous active low; the hash returns to its initial values.
// a stalled output holds its beat; input is not taken while work is under way.
module sha256_message_hasher
    import sha256_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  in_beat_t  in_data,
    output logic      out_valid,
    input  logic      out_ready,
    output out_beat_t out_data
);

    dp_cmd_t     cmd;
    logic [5:0]  load_addr;
    logic        load_en;
    logic [31:0] emit_word;
    logic        out_busy;
    logic        out_load;
    logic [2:0]  out_idx;
    logic        in_fire;

    assign in_fire   = in_valid && in_ready;
    assign out_valid = out_busy;

    sha256_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_fire   (in_fire),
        .in_beat   (in_data),
        .in_ready  (in_ready),
        .out_taken (out_valid && out_ready),
        .out_busy  (out_busy),
        .out_idx   (out_idx),
        .out_load  (out_load),
        .cmd       (cmd),
        .load_addr (load_addr),
        .load_en   (load_en)
    );

    sha256_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .load_addr (load_addr),
        .load_en   (load_en),
        .emit_word (emit_word)
    );

    // output beat straight from the hash word register
    always_comb
    begin
        out_data.digest_word = emit_word;
        out_data.word_index  = out_idx;
        out_data.last_word   = out_load && (out_idx == 3'd7);
    end

endmodule

FILE: tb/testbench.sv
// testbench for sha256_message_hasher: drives random and directed messages byte by byte,
// predicts the eight digest words per finish with its own sha-256 model and checks each beat
// depends on sha256_pkg and sha256_message_hasher
`timescale 1ns / 100ps

module testbench;
    import sha256_pkg::*;

    // digest tracker: sha-256 state and queue of expected digest beats
    class digest_scoreboard;
        logic [31:0] hash_st [8];
        logic [7:0]  blk [64];
        int unsigned fill;
        logic [63:0] bit_len;
        out_beat_t   digest_q [$];
        int unsigned mismatches;

        function void init_state();
            for (int i = 0; i < 8; i++) hash_st[i] = InitHash[i];
            fill = 0;
            bit_len = '0;
        endfunction

        function new();
            mismatches = 0;
            for (int i = 0; i < 64; i++) blk[i] = '0;
            init_state();
        endfunction

        function logic [31:0] ror(logic [31:0] x, int n);
            return (x >> n) | (x << (32 - n));
        endfunction

        function void compress();
            logic [31:0] w [16];
            logic [31:0] v [8];
            logic [31:0] wr, t1, t2, a, e;
            for (int t = 0; t < 16; t++)
                w[t] = {blk[4*t], blk[4*t+1], blk[4*t+2], blk[4*t+3]};
            for (int t = 0; t < 8; t++) v[t] = hash_st[t];
            for (int r = 0; r < 64; r++)
            begin
                if (r < 16)
                    wr = w[r];
                else
                begin
                    wr = (ror(w[(r-2)&15], 17) ^ ror(w[(r-2)&15], 19) ^ (w[(r-2)&15] >> 10))
                       + w[(r-7)&15]
                       + (ror(w[(r-15)&15], 7) ^ ror(w[(r-15)&15], 18) ^ (w[(r-15)&15] >> 3))
                       + w[r&15];
                    w[r&15] = wr;
                end
                a = v[0];
                e = v[4];
                t1 = v[7] + (ror(e, 6) ^ ror(e, 11) ^ ror(e, 25)) + ((e & v[5]) ^ (~e & v[6]))
                   + RoundK[r] + wr;
                t2 = (ror(a, 2) ^ ror(a, 13) ^ ror(a, 22)) + ((a & v[1]) ^ (a & v[2]) ^ (v[1] & v[2]));
                v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
                v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
            end
            for (int t = 0; t < 8; t++) hash_st[t] += v[t];
        endfunction

        // note an accepted input beat
        function void note_input(in_beat_t b);
            logic [63:0] total;
            out_beat_t   o;
            if (op_t'(b.opcode) == OP_ABSORB)
            begin
                blk[fill] = b.data_byte;
                fill++;
                if (fill == 64)
                begin
                    compress();
                    bit_len += BlockBits;
                    fill = 0;
                end
                return;
            end
            total = bit_len + 64'(fill) * 8;
            blk[fill] = PadByte;
            for (int i = fill + 1; i < 64; i++) blk[i] = '0;
            if (fill >= LenBytePos)
            begin
                compress();
                for (int i = 0; i < 56; i++) blk[i] = '0;
            end
            for (int i = 0; i < 8; i++) blk[56+i] = total[63-8*i -: 8];
            compress();
            for (int i = 0; i < 8; i++)
            begin
                o.digest_word = hash_st[i];
                o.word_index  = 3'(i);
                o.last_word   = (i == 7);
                digest_q.push_back(o);
            end
            init_state();
        endfunction

        // check an accepted output beat against the oldest expectation
        function void check_output(out_beat_t got);
            out_beat_t exp_b;
            if (digest_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected digest beat %h", got);
                return;
            end
            exp_b = digest_q.pop_front();
            if (got.digest_word !== exp_b.digest_word || got.word_index !== exp_b.word_index
                || got.last_word !== exp_b.last_word)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("digest mismatch: expected %h/%0d/%0b got %h/%0d/%0b",
                             exp_b.digest_word, exp_b.word_index, exp_b.last_word,
                             got.digest_word, got.word_index, got.last_word);
            end
        endfunction
    endclass

    localparam int unsigned StallLimit = 20000;

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_ready;
    in_beat_t  in_data;
    logic      out_valid;
    logic      out_ready;
    out_beat_t out_data;

    digest_scoreboard sb;
    bit          calm;
    int unsigned idle_cycles;
    bit          timed_out;

    sha256_message_hasher u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    function bit gap_now();
        return !calm && ($urandom_range(99) < 22);
    endfunction

    // send one beat, with random gaps ahead of it
    task automatic send_beat(op_t op, logic [7:0] value);
        while (gap_now())
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= '{opcode: op, data_byte: value};
        do
            @(posedge clk);
        while (!in_ready);
        sb.note_input('{opcode: op, data_byte: value});
    endtask

    task automatic send_message(int unsigned len, bit ones);
        for (int unsigned i = 0; i < len; i++)
            send_beat(OP_ABSORB, ones ? 8'hff : 8'($urandom_range(255)));
        send_beat(OP_FINISH, 8'($urandom_range(255)));
    endtask

    // output side: random stalls, check every accepted beat
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready) sb.check_output(out_data);
            out_ready <= !gap_now();
        end
    end

    // watchdog on cycles with no accepted beat
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= StallLimit && !timed_out)
        begin
            timed_out = 1'b1;
            $display("tb: failure");
            $finish;
        end
    end

    initial
    begin
        sb          = new();
        calm        = 1'b0;
        idle_cycles = 0;
        timed_out   = 1'b0;
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        in_data     = '0;
        out_ready   = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty message, byte extremes, padding edge lengths
        send_beat(OP_FINISH, 8'h00);
        send_beat(OP_ABSORB, 8'h00);
        send_beat(OP_FINISH, 8'hff);
        send_beat(OP_ABSORB, 8'hff);
        send_beat(OP_FINISH, 8'h00);
        send_message(3, 1'b0);
        send_message(55, 1'b1);
        send_message(56, 1'b0);
        send_message(63, 1'b1);
        send_message(64, 1'b0);

        // a stretch of no idling on either side
        calm = 1'b1;
        send_message(40 + $urandom_range(20), 1'b0);
        calm = 1'b0;

        // random messages
        for (int m = 0; m < 2; m++)
        begin
            case ($urandom_range(2))
                0: send_message($urandom_range(8), 1'b0);
                1: send_message(54 + $urandom_range(10), 1'b0);
                default: send_message($urandom_range(70), 1'b0);
            endcase
        end
        in_valid <= 1'b0;

        // drain
        while (sb.digest_q.size() != 0)
            @(posedge clk);
        repeat (50) @(posedge clk);
        if (sb.mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end
endmodule
